@@ rtl/core/fte_pkg.sv @@
// Shared widths, opcodes and walk-step types for the Fenwick tree engine.
// No dependencies; every other file refers to it by scoped names.
package fte_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = 11;
   localparam int POS_W  = IDX_W + 1;
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_POINT_ADD = 2'd0,
      OP_RANGE_ADD = 2'd1,
      OP_PREFIX    = 2'd2,
      OP_RANGE_SUM = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [POS_W-1:0]  up_pos;
      logic [POS_W-1:0]  down_pos;
      logic              up_ok;
   } step_type;

endpackage

@@ rtl/core/fte_walk.sv @@
// Walk step of the binary indexed tree: lowest set bit, next positions, address.
// Depends on fte_pkg for widths and step_type.
module fte_walk (
   input  logic [fte_pkg::POS_W-1:0] walk_pos,
   input  logic [fte_pkg::POS_W-1:0] walk_n,
   output fte_pkg::step_type         walk_step
);

   logic [fte_pkg::POS_W-1:0] low_bit;
   logic [fte_pkg::POS_W-1:0] up_pos;
   logic [fte_pkg::POS_W-1:0] addr_full;

   assign low_bit   = walk_pos & (~walk_pos + fte_pkg::POS_W'(1));
   assign up_pos    = walk_pos + low_bit;
   assign addr_full = walk_pos - fte_pkg::POS_W'(1);

   assign walk_step.addr     = addr_full[fte_pkg::ADDR_W-1:0];
   assign walk_step.up_pos   = up_pos;
   assign walk_step.down_pos = walk_pos - low_bit;
   assign walk_step.up_ok    = (up_pos <= walk_n);

endmodule

@@ rtl/core/fenwick_tree_engine.sv @@
// Fenwick tree engine top level: sequencer, partial-sum memory, size register.
// Depends on fte_pkg and fte_walk.
//
//   channel   ports                                      handshake
//   request   req_opcode/first_index/last_index/amount   start & !busy
//   result    rsp_sum_result                             rsp_strobe, one cycle
//   config    csr_size_in_use                            csr_we
//
// Each tree entry visited takes a read state, then a write-back state for updates
// or an accumulate state for queries. After reset a clearing pass writes the 1024
// entries with busy high. The result is registered and appears in the cycle after
// the last step; the receiver cannot stall.
module fenwick_tree_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [fte_pkg::OP_W-1:0]          req_opcode,
   input  logic [fte_pkg::IDX_W-1:0]         req_first_index,
   input  logic [fte_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [fte_pkg::DATA_W-1:0] req_amount,
   output logic                              rsp_strobe,
   output logic signed [fte_pkg::DATA_W-1:0] rsp_sum_result,
   input  logic                              csr_we,
   input  logic [fte_pkg::IDX_W-1:0]         csr_size_in_use
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_NEXT,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_QRY_RD,
      ST_QRY_ACC
   } state_type;

   state_type                  state_ff, state_in;
   logic [fte_pkg::IDX_W-1:0]  size_ff;
   logic [fte_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic [fte_pkg::POS_W-1:0]  cur_ff, cur_in;
   logic [fte_pkg::POS_W-1:0]  end_ff, end_in;
   logic [fte_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [fte_pkg::POS_W-1:0]  second_pos_ff, second_pos_in;
   logic                       second_ff, second_in;
   logic                       neg_ff, neg_in;
   logic [fte_pkg::DATA_W-1:0] amt_ff, amt_in;
   logic [fte_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [fte_pkg::DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic [fte_pkg::DATA_W-1:0] mem [fte_pkg::DEPTH];
   logic [fte_pkg::DATA_W-1:0] rdata_ff;
   logic                       mem_we;
   logic [fte_pkg::ADDR_W-1:0] mem_waddr;
   logic [fte_pkg::DATA_W-1:0] mem_wdata;

   logic [fte_pkg::POS_W-1:0]  n_eff;
   logic [fte_pkg::POS_W-1:0]  first_ext;
   logic [fte_pkg::POS_W-1:0]  last_ext;
   fte_pkg::step_type          step;

   function automatic logic [fte_pkg::POS_W-1:0] clamp_pos(
      input logic [fte_pkg::POS_W-1:0] v,
      input logic [fte_pkg::POS_W-1:0] lim
   );
      return (v > lim) ? lim : v;
   endfunction

   assign n_eff = ({1'b0, size_ff} > fte_pkg::POS_W'(fte_pkg::DEPTH))
                  ? fte_pkg::POS_W'(fte_pkg::DEPTH) : {1'b0, size_ff};
   assign first_ext = {1'b0, req_first_index};
   assign last_ext  = {1'b0, req_last_index};

   fte_walk u_walk (
      .walk_pos  (pos_ff),
      .walk_n    (n_eff),
      .walk_step (step)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      second_pos_in = second_pos_ff;
      second_in     = second_ff;
      neg_in        = neg_ff;
      amt_in        = amt_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_sum_in    = rsp_sum_ff;
      mem_we        = 1'b0;
      mem_waddr     = step.addr;
      mem_wdata     = rdata_ff + amt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + fte_pkg::ADDR_W'(1);
            if (clr_ff == fte_pkg::ADDR_W'(fte_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               amt_in    = req_amount;
               acc_in    = '0;
               neg_in    = 1'b0;
               second_in = 1'b0;
               unique case (fte_pkg::opcode_type'(req_opcode))
                  fte_pkg::OP_POINT_ADD: begin
                     cur_in   = first_ext;
                     end_in   = first_ext;
                     state_in = ST_UPD_NEXT;
                  end
                  fte_pkg::OP_RANGE_ADD: begin
                     cur_in   = (first_ext == '0) ? fte_pkg::POS_W'(1) : first_ext;
                     end_in   = clamp_pos(last_ext, n_eff);
                     state_in = ST_UPD_NEXT;
                  end
                  fte_pkg::OP_PREFIX: begin
                     pos_in   = clamp_pos(first_ext, n_eff);
                     state_in = ST_QRY_RD;
                  end
                  fte_pkg::OP_RANGE_SUM: begin
                     pos_in        = clamp_pos(last_ext, n_eff);
                     second_in     = (first_ext != '0);
                     second_pos_in = clamp_pos(first_ext - fte_pkg::POS_W'(1), n_eff);
                     state_in      = ST_QRY_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPD_NEXT: begin
            if (cur_ff != '0 && cur_ff <= end_ff && cur_ff <= n_eff) begin
               pos_in   = cur_ff;
               state_in = ST_UPD_RD;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_sum_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            mem_we = 1'b1;
            if (step.up_ok) begin
               pos_in   = step.up_pos;
               state_in = ST_UPD_RD;
            end else begin
               cur_in   = cur_ff + fte_pkg::POS_W'(1);
               state_in = ST_UPD_NEXT;
            end
         end
         ST_QRY_RD: begin
            if (pos_ff == '0) begin
               if (second_ff) begin
                  pos_in    = second_pos_ff;
                  second_in = 1'b0;
                  neg_in    = 1'b1;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_sum_in    = acc_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_QRY_ACC;
            end
         end
         ST_QRY_ACC: begin
            acc_in   = neg_ff ? (acc_ff - rdata_ff) : (acc_ff + rdata_ff);
            pos_in   = step.down_pos;
            state_in = ST_QRY_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff        <= cur_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      second_pos_ff <= second_pos_in;
      second_ff     <= second_in;
      neg_ff        <= neg_in;
      amt_ff        <= amt_in;
      acc_ff        <= acc_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= fte_pkg::IDX_W'(1024);
      end else if (csr_we) begin
         size_ff <= csr_size_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[step.addr];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_sum_result = rsp_sum_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_strobe)
      else $error("result during clearing pass");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_UPD_WR || state_ff == ST_CLEAR))
      else $error("memory write outside update or clear");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE || $past(start && !busy)))
      else $error("result strobe while walk still running");

endmodule

@@ test/tb_fenwick_tree_engine.sv @@
// Testbench for fenwick_tree_engine: directed and random requests checked against
// a local binary indexed tree predictor under several size settings.
// Depends on fte_pkg and the fenwick_tree_engine RTL.
`timescale 1ns / 1ps

module tb_fenwick_tree_engine;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 100_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int MAX_INDEX    = (1 << fte_pkg::IDX_W) - 1;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [fte_pkg::OP_W-1:0]          req_opcode;
   logic [fte_pkg::IDX_W-1:0]         req_first_index;
   logic [fte_pkg::IDX_W-1:0]         req_last_index;
   logic signed [fte_pkg::DATA_W-1:0] req_amount;
   logic                              rsp_strobe;
   logic signed [fte_pkg::DATA_W-1:0] rsp_sum_result;
   logic                              csr_we;
   logic [fte_pkg::IDX_W-1:0]         csr_size_in_use;

   logic [fte_pkg::DATA_W-1:0] tree_sums [1:fte_pkg::DEPTH];
   logic [fte_pkg::IDX_W-1:0]  size_setting;
   logic [fte_pkg::DATA_W-1:0] expected_sums [$];
   int                         failure_count = 0;
   int                         burst_left = 0;

   fenwick_tree_engine u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_amount      (req_amount),
      .rsp_strobe      (rsp_strobe),
      .rsp_sum_result  (rsp_sum_result),
      .csr_we          (csr_we),
      .csr_size_in_use (csr_size_in_use)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned lowest_bit(int unsigned v);
      return v & (~v + 1);
   endfunction

   function automatic int unsigned used_size();
      return (size_setting > fte_pkg::DEPTH) ? fte_pkg::DEPTH : size_setting;
   endfunction

   function automatic void tree_add(int unsigned pos, logic [fte_pkg::DATA_W-1:0] amt,
                                    int unsigned n);
      while (pos != 0 && pos <= n) begin
         tree_sums[pos] += amt;
         pos += lowest_bit(pos);
      end
   endfunction

   function automatic logic [fte_pkg::DATA_W-1:0] prefix_total(int unsigned pos,
                                                               int unsigned n);
      logic [fte_pkg::DATA_W-1:0] acc;
      acc = '0;
      if (pos > n) pos = n;
      while (pos != 0) begin
         acc += tree_sums[pos];
         pos -= lowest_bit(pos);
      end
      return acc;
   endfunction

   function automatic logic [fte_pkg::DATA_W-1:0] apply_request(
      fte_pkg::opcode_type op,
      logic [fte_pkg::IDX_W-1:0] first,
      logic [fte_pkg::IDX_W-1:0] last,
      logic [fte_pkg::DATA_W-1:0] amt);
      int unsigned n, p, stop;
      logic [fte_pkg::DATA_W-1:0] lower;
      n = used_size();
      case (op)
         fte_pkg::OP_POINT_ADD: begin
            tree_add(first, amt, n);
            return '0;
         end
         fte_pkg::OP_RANGE_ADD: begin
            p = (first == 0) ? 1 : first;
            stop = (last > n) ? n : last;
            for (; p <= stop; p++) tree_add(p, amt, n);
            return '0;
         end
         fte_pkg::OP_PREFIX: begin
            return prefix_total(first, n);
         end
         default: begin
            lower = (first == 0) ? '0 : prefix_total(first - 1, n);
            return prefix_total(last, n) - lower;
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [fte_pkg::IDX_W-1:0] pick_index(int unsigned n);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return fte_pkg::IDX_W'(fte_pkg::DEPTH);
      if (r < 12) return fte_pkg::IDX_W'($urandom_range(fte_pkg::DEPTH + 1, MAX_INDEX));
      if (r < 24) return fte_pkg::IDX_W'(n + $urandom_range(0, 1));
      if (n == 0) return fte_pkg::IDX_W'($urandom_range(1, 8));
      return fte_pkg::IDX_W'($urandom_range(1, n));
   endfunction

   function automatic logic [fte_pkg::DATA_W-1:0] pick_amount();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return 32'h7FFF_FFFF;
      if (r < 12) return 32'h8000_0000;
      if (r < 18) return '1;
      if (r < 40) return fte_pkg::DATA_W'($urandom_range(0, 200)) - 32'd100;
      return $urandom;
   endfunction

   task automatic send_request(fte_pkg::opcode_type op, logic [fte_pkg::IDX_W-1:0] first,
                               logic [fte_pkg::IDX_W-1:0] last,
                               logic [fte_pkg::DATA_W-1:0] amt);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode      <= op;
      req_first_index <= first;
      req_last_index  <= last;
      req_amount      <= amt;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_sums.push_back(apply_request(op, first, last, amt));
   endtask

   task automatic send_random_request();
      fte_pkg::opcode_type op;
      logic [fte_pkg::IDX_W-1:0] first, last;
      int unsigned n, r, span;
      n = used_size();
      op = fte_pkg::opcode_type'($urandom_range(0, 3));
      first = pick_index(n);
      last = pick_index(n);
      r = $urandom_range(0, 99);
      if (op == fte_pkg::OP_RANGE_ADD) begin
         if (r < 3) begin
            first = fte_pkg::IDX_W'($urandom_range(1, MAX_INDEX));
            last = fte_pkg::IDX_W'($urandom_range(0, first - 1));
         end else if (r < 4) begin
            first = fte_pkg::IDX_W'($urandom_range(0, 1));
            last = fte_pkg::IDX_W'($urandom_range(fte_pkg::DEPTH, MAX_INDEX));
         end else begin
            span = first + $urandom_range(0, 12);
            last = (span > MAX_INDEX) ? fte_pkg::IDX_W'(MAX_INDEX) : fte_pkg::IDX_W'(span);
         end
      end else if (op == fte_pkg::OP_RANGE_SUM && r < 75 && first > last) begin
         {first, last} = {last, first};
      end
      send_request(op, first, last, pick_amount());
   endtask

   task automatic run_random(int count);
      repeat (count) send_random_request();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_sums.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic set_size(logic [fte_pkg::IDX_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we          <= 1'b1;
      csr_size_in_use <= value;
      size_setting = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic note_failure(string what, logic [fte_pkg::DATA_W-1:0] want,
                               logic [fte_pkg::DATA_W-1:0] got);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("%0t: %s: expected sum_result %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      logic [fte_pkg::DATA_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_sums.size() == 0) begin
            note_failure("response with no request pending", 'x, rsp_sum_result);
         end else begin
            want = expected_sums.pop_front();
            if (rsp_sum_result !== want) note_failure("sum mismatch", want, rsp_sum_result);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic test_cleared_tree();
      send_request(fte_pkg::OP_PREFIX, fte_pkg::IDX_W'(fte_pkg::DEPTH), '0, '0);
      send_request(fte_pkg::OP_RANGE_SUM, '0, fte_pkg::IDX_W'(MAX_INDEX), '0);
   endtask

   task automatic test_special_cases();
      send_request(fte_pkg::OP_POINT_ADD, '0, '0, 32'h7FFF_FFFF);
      send_request(fte_pkg::OP_POINT_ADD, 11'd1, '0, 32'h7FFF_FFFF);
      send_request(fte_pkg::OP_POINT_ADD, fte_pkg::IDX_W'(fte_pkg::DEPTH), '0, 32'h8000_0000);
      send_request(fte_pkg::OP_POINT_ADD, fte_pkg::IDX_W'(MAX_INDEX), '0, 32'd5);
      send_request(fte_pkg::OP_POINT_ADD, fte_pkg::IDX_W'(fte_pkg::DEPTH + 1), '0, '1);
      send_request(fte_pkg::OP_RANGE_ADD, '0, 11'd3, '1);
      send_request(fte_pkg::OP_RANGE_ADD, 11'd10, 11'd9, 32'd100);
      send_request(fte_pkg::OP_RANGE_ADD, 11'd1020, fte_pkg::IDX_W'(MAX_INDEX), 32'd7);
      send_request(fte_pkg::OP_PREFIX, '0, fte_pkg::IDX_W'(MAX_INDEX), '1);
      send_request(fte_pkg::OP_PREFIX, fte_pkg::IDX_W'(MAX_INDEX), '0, '0);
      send_request(fte_pkg::OP_PREFIX, 11'd1, '0, '0);
      send_request(fte_pkg::OP_RANGE_SUM, '0, fte_pkg::IDX_W'(fte_pkg::DEPTH), '0);
      send_request(fte_pkg::OP_RANGE_SUM, 11'd500, 11'd3, '0);
      send_request(fte_pkg::OP_RANGE_SUM, 11'd1, 11'd1, '0);
      send_request(fte_pkg::OP_PREFIX, fte_pkg::IDX_W'(fte_pkg::DEPTH - 1), '0, '0);
      send_request(fte_pkg::OP_RANGE_ADD, '0, fte_pkg::IDX_W'(MAX_INDEX), 32'd1);
      send_request(fte_pkg::OP_RANGE_SUM, fte_pkg::IDX_W'(fte_pkg::DEPTH),
                   fte_pkg::IDX_W'(fte_pkg::DEPTH), '0);
      send_request(fte_pkg::OP_PREFIX, 11'd512, '0, '0);
   endtask

   task automatic test_size_extremes();
      set_size(11'd1);
      run_random(60);
      set_size('0);
      run_random(30);
      set_size(fte_pkg::IDX_W'(MAX_INDEX));
      run_random(100);
   endtask

   task automatic test_shrink_and_grow();
      set_size(fte_pkg::IDX_W'(fte_pkg::DEPTH));
      run_random(60);
      set_size(11'd5);
      run_random(60);
      set_size(fte_pkg::IDX_W'(fte_pkg::DEPTH));
      run_random(60);
   endtask

   task automatic test_random_traffic();
      set_size(11'd16);
      run_random(96);
      set_size(fte_pkg::IDX_W'($urandom_range(2, fte_pkg::DEPTH - 1)));
      run_random(96);
      set_size(fte_pkg::IDX_W'(fte_pkg::DEPTH - 1));
      run_random(96);
      set_size(fte_pkg::IDX_W'($urandom_range(1, fte_pkg::DEPTH)));
      run_random(96);
      set_size(fte_pkg::IDX_W'(fte_pkg::DEPTH));
      run_random(96);
   endtask

   initial begin
      foreach (tree_sums[i]) tree_sums[i] = '0;
      size_setting    = fte_pkg::IDX_W'(fte_pkg::DEPTH);
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = '0;
      req_first_index = '0;
      req_last_index  = '0;
      req_amount      = '0;
      csr_we          = 1'b0;
      csr_size_in_use = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cleared_tree();
      test_special_cases();
      test_size_extremes();
      test_shrink_and_grow();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && expected_sums.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
